### hdl/mpls_pkg.sv
`timescale 1ns / 1ps
package mpls_pkg;

  localparam int MOTOR_MAX       = 4;
  localparam int MOTOR_COUNT_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_SQ_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SQ_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_POWER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT    = 3'd4;

  localparam logic [31:0] RST_TORQUE_SQ_GAIN = 32'd98435;
  localparam logic [31:0] RST_SPEED_SQ_GAIN  = 32'd328;
  localparam logic [31:0] RST_STATIC_POWER   = 32'd65536;
  localparam logic [31:0] RST_TORQUE_GAIN    = 32'd6144;
  localparam logic [15:0] RST_POWER_LIMIT    = 16'd60;

  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_ZERO = 2'd1;
  localparam logic [1:0] SEL_ROOT = 2'd2;

  localparam int SUM_W  = 62;
  localparam int BM_W   = 49;
  localparam int DVS_W  = 63;
  localparam int DISC_W = 126;
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int NUM_W  = 64;
  localparam int QF_W   = 16;
  localparam int QW     = 19;
  localparam int DIVN_W = NUM_W + QF_W + 2;
  localparam int SCALE_W = 20;

  localparam int FRONT_STAGES = 11;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = QW;

  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(1) << (SUM_W - 1);
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(524287);
  localparam logic [SCALE_W-1:0] SCALE_SAT = SCALE_W'(524288);

  typedef logic [MOTOR_MAX-1:0][31:0] tq_t;
  typedef logic [MOTOR_MAX-1:0][15:0] fld16_t;

  typedef struct packed {
    logic [31:0] k2;
    logic [31:0] k1;
    logic [31:0] stat;
    logic [31:0] tgain;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    tq_t              torque;
    logic [31:0]      power;
    logic [1:0]       sel;
    logic             b_pos;
    logic [BM_W-1:0]  bm;
    logic [DVS_W-1:0] dvs;
  } side_t;

endpackage

### hdl/mpls_front.sv
`timescale 1ns / 1ps
module mpls_front #(
  parameter int MOTOR_COUNT = mpls_pkg::MOTOR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mpls_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mpls_pkg::fld16_t                 in_cur,
  input  mpls_pkg::fld16_t                 in_spd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpls_pkg::DISC_W-1:0]      out_disc,
  output mpls_pkg::side_t                  out_side
);

  localparam int M = mpls_pkg::MOTOR_MAX;
  localparam int NS = mpls_pkg::FRONT_STAGES;
  localparam int SW = mpls_pkg::SUM_W;
  localparam int BW = mpls_pkg::BM_W;
  localparam int DW = mpls_pkg::DISC_W;

  logic en;
  logic [NS-1:0] vld_r;
  logic [M-1:0] mot_en;

  logic signed [48:0] s1_tp_r [M];
  logic [30:0]        s1_vsq_r [M];
  logic signed [15:0] s1_v_r [M];

  logic signed [31:0] s2_t_nxt [M];
  logic signed [31:0] s2_t_r [M];
  logic [31:0]        s2_tm_r [M];
  logic [62:0]        s2_vk_r [M];
  logic signed [15:0] s2_v_r [M];

  mpls_pkg::tq_t      s3_t_r;
  logic [62:0]        s3_tt_r [M];
  logic signed [47:0] s3_tv_r [M];
  logic [62:0]        s3_vk_r [M];

  mpls_pkg::tq_t      s4_t_r;
  logic [62:0]        s4_ahi_r [M];
  logic [63:0]        s4_alo_r [M];
  logic signed [47:0] s4_tv_r [M];
  logic [62:0]        s4_vk_r [M];

  mpls_pkg::tq_t      s5_t_r;
  logic [62:0]        s5_aterm_r [M];
  logic [62:0]        s5_cterm_r [M];
  logic signed [47:0] s5_tv_r [M];

  logic [64:0]        s6_asum_nxt;
  logic [64:0]        s6_csum_nxt;
  logic signed [49:0] s6_b_nxt;
  mpls_pkg::tq_t      s6_t_r;
  logic [SW-1:0]      s6_a_r;
  logic [SW-1:0]      s6_c_r;
  logic signed [49:0] s6_b_r;

  mpls_pkg::tq_t      s7_t_r;
  logic [SW-1:0]      s7_a_r;
  logic signed [63:0] s7_pwr_r;
  logic signed [63:0] s7_cp_r;
  logic [BW-1:0]      s7_bm_r;
  logic               s7_bpos_r;

  logic signed [63:0] s8_psh;
  logic [31:0]        s8_pw_nxt;
  mpls_pkg::tq_t      s8_t_r;
  logic [SW-1:0]      s8_a_r;
  logic [31:0]        s8_pw_r;
  logic               s8_ge_r;
  logic [SW-1:0]      s8_cm_r;
  logic               s8_cppos_r;
  logic               s8_azero_r;
  logic [BW-1:0]      s8_bm_r;
  logic               s8_bpos_r;

  logic [63:0]        s9_a4;
  mpls_pkg::tq_t      s9_t_r;
  logic [SW-1:0]      s9_a_r;
  logic [31:0]        s9_pw_r;
  logic               s9_ge_r;
  logic               s9_cppos_r;
  logic               s9_azero_r;
  logic [BW-1:0]      s9_bm_r;
  logic               s9_bpos_r;
  logic [63:0]        s9_p00_r;
  logic [61:0]        s9_p01_r;
  logic [63:0]        s9_p10_r;
  logic [61:0]        s9_p11_r;
  logic [63:0]        s9_q00_r;
  logic [48:0]        s9_q01_r;
  logic [33:0]        s9_q11_r;

  mpls_pkg::tq_t      s10_t_r;
  logic [SW-1:0]      s10_a_r;
  logic [31:0]        s10_pw_r;
  logic               s10_ge_r;
  logic               s10_cppos_r;
  logic               s10_azero_r;
  logic [BW-1:0]      s10_bm_r;
  logic               s10_bpos_r;
  logic [DW-1:0]      s10_fac_r;
  logic [DW-1:0]      s10_bsq_r;

  logic [DW-1:0]      s11_sum;
  logic [DW-1:0]      s11_diff;
  logic               s11_gt;
  logic               s11_pos;
  logic [DW-1:0]      s11_disc_nxt;
  mpls_pkg::side_t    s11_side_nxt;
  logic [DW-1:0]      s11_disc_r;
  mpls_pkg::side_t    s11_side_r;

  assign en        = !vld_r[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NS-1];
  assign out_disc  = s11_disc_r;
  assign out_side  = s11_side_r;

  always_comb begin
    for (int i = 0; i < M; i++) begin
      mot_en[i] = (i < MOTOR_COUNT);
      if (!mot_en[i]) begin
        s2_t_nxt[i] = '0;
      end else if (s1_tp_r[i] > 49'sd2147483647) begin
        s2_t_nxt[i] = 32'sh7FFFFFFF;
      end else if (s1_tp_r[i] < -49'sd2147483648) begin
        s2_t_nxt[i] = 32'sh80000000;
      end else begin
        s2_t_nxt[i] = s1_tp_r[i][31:0];
      end
    end
  end

  always_comb begin
    s6_asum_nxt = '0;
    s6_csum_nxt = '0;
    s6_b_nxt    = '0;
    for (int i = 0; i < M; i++) begin
      s6_asum_nxt = s6_asum_nxt + 65'(s5_aterm_r[i]);
      s6_csum_nxt = s6_csum_nxt + 65'(s5_cterm_r[i]);
      s6_b_nxt    = s6_b_nxt + 50'(s5_tv_r[i]);
    end
  end

  always_comb begin
    s8_psh = s7_pwr_r >>> 16;
    if (s8_psh > 64'sd2147483647) begin
      s8_pw_nxt = 32'h7FFFFFFF;
    end else if (s8_psh < -64'sd2147483648) begin
      s8_pw_nxt = 32'h80000000;
    end else begin
      s8_pw_nxt = s8_psh[31:0];
    end
    s9_a4 = {s8_a_r, 2'b00};
  end

  always_comb begin
    s11_sum  = s10_bsq_r + s10_fac_r;
    s11_diff = s10_bsq_r - s10_fac_r;
    s11_gt   = s10_bsq_r > s10_fac_r;
    if (s10_cppos_r) begin
      s11_pos      = s11_gt;
      s11_disc_nxt = s11_gt ? s11_diff : s10_bsq_r;
    end else begin
      s11_pos      = s11_sum != '0;
      s11_disc_nxt = s11_sum;
    end
    s11_side_nxt.torque = s10_t_r;
    s11_side_nxt.power  = s10_pw_r;
    s11_side_nxt.b_pos  = s10_bpos_r;
    s11_side_nxt.bm     = s10_bm_r;
    s11_side_nxt.dvs    = {s10_a_r, 1'b0};
    if (!s10_ge_r) begin
      s11_side_nxt.sel = mpls_pkg::SEL_ONE;
    end else if (!s11_pos || s10_azero_r) begin
      s11_side_nxt.sel = mpls_pkg::SEL_ZERO;
    end else begin
      s11_side_nxt.sel = mpls_pkg::SEL_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < M; i++) begin
        s1_tp_r[i]  <= 49'($signed(in_cur[i])) * 49'($signed({1'b0, cfg.tgain}));
        s1_vsq_r[i] <= 31'(32'($signed(in_spd[i])) * 32'($signed(in_spd[i])));
        s1_v_r[i]   <= $signed(in_spd[i]);

        s2_t_r[i]  <= s2_t_nxt[i];
        s2_tm_r[i] <= s2_t_nxt[i][31] ? 32'(-s2_t_nxt[i]) : 32'(s2_t_nxt[i]);
        s2_vk_r[i] <= 63'(s1_vsq_r[i]) * 63'(cfg.k1);
        s2_v_r[i]  <= s1_v_r[i];

        s3_t_r[i]  <= s2_t_r[i];
        s3_tt_r[i] <= 63'(s2_tm_r[i]) * 63'(s2_tm_r[i]);
        s3_tv_r[i] <= 48'(s2_t_r[i]) * 48'(s2_v_r[i]);
        s3_vk_r[i] <= s2_vk_r[i];

        s4_t_r[i]   <= s3_t_r[i];
        s4_ahi_r[i] <= 63'(s3_tt_r[i][62:32]) * 63'(cfg.k2);
        s4_alo_r[i] <= 64'(s3_tt_r[i][31:0]) * 64'(cfg.k2);
        s4_tv_r[i]  <= s3_tv_r[i];
        s4_vk_r[i]  <= s3_vk_r[i];

        s5_t_r[i]     <= s4_t_r[i];
        s5_aterm_r[i] <= s4_ahi_r[i] + 63'(s4_alo_r[i][63:32]);
        s5_cterm_r[i] <= mot_en[i] ? s4_vk_r[i] + 63'({cfg.stat, 16'h0000}) : '0;
        s5_tv_r[i]    <= s4_tv_r[i];
      end

      s6_t_r <= s5_t_r;
      s6_a_r <= (s6_asum_nxt >= 65'(mpls_pkg::SUM_CAP)) ? mpls_pkg::SUM_CAP
                                                         : s6_asum_nxt[SW-1:0];
      s6_c_r <= (s6_csum_nxt >= 65'(mpls_pkg::SUM_CAP)) ? mpls_pkg::SUM_CAP
                                                         : s6_csum_nxt[SW-1:0];
      s6_b_r <= s6_b_nxt;

      s7_t_r    <= s6_t_r;
      s7_a_r    <= s6_a_r;
      s7_pwr_r  <= $signed(64'(s6_a_r)) + 64'(s6_b_r) + $signed(64'(s6_c_r));
      s7_cp_r   <= $signed(64'(s6_c_r)) - $signed({16'h0000, cfg.limit, 32'h0});
      s7_bm_r   <= s6_b_r[49] ? BW'(-s6_b_r) : BW'(s6_b_r);
      s7_bpos_r <= s6_b_r > 50'sd0;

      s8_t_r     <= s7_t_r;
      s8_a_r     <= s7_a_r;
      s8_pw_r    <= s8_pw_nxt;
      s8_ge_r    <= s7_pwr_r >= $signed({16'h0000, cfg.limit, 32'h0});
      s8_cm_r    <= s7_cp_r[63] ? SW'(-s7_cp_r) : SW'(s7_cp_r);
      s8_cppos_r <= s7_cp_r > 64'sd0;
      s8_azero_r <= s7_a_r == '0;
      s8_bm_r    <= s7_bm_r;
      s8_bpos_r  <= s7_bpos_r;

      s9_t_r     <= s8_t_r;
      s9_a_r     <= s8_a_r;
      s9_pw_r    <= s8_pw_r;
      s9_ge_r    <= s8_ge_r;
      s9_cppos_r <= s8_cppos_r;
      s9_azero_r <= s8_azero_r;
      s9_bm_r    <= s8_bm_r;
      s9_bpos_r  <= s8_bpos_r;
      s9_p00_r   <= 64'(s9_a4[31:0]) * 64'(s8_cm_r[31:0]);
      s9_p01_r   <= 62'(s9_a4[31:0]) * 62'(s8_cm_r[61:32]);
      s9_p10_r   <= 64'(s9_a4[63:32]) * 64'(s8_cm_r[31:0]);
      s9_p11_r   <= 62'(s9_a4[63:32]) * 62'(s8_cm_r[61:32]);
      s9_q00_r   <= 64'(s8_bm_r[31:0]) * 64'(s8_bm_r[31:0]);
      s9_q01_r   <= 49'(s8_bm_r[31:0]) * 49'(s8_bm_r[48:32]);
      s9_q11_r   <= 34'(s8_bm_r[48:32]) * 34'(s8_bm_r[48:32]);

      s10_t_r     <= s9_t_r;
      s10_a_r     <= s9_a_r;
      s10_pw_r    <= s9_pw_r;
      s10_ge_r    <= s9_ge_r;
      s10_cppos_r <= s9_cppos_r;
      s10_azero_r <= s9_azero_r;
      s10_bm_r    <= s9_bm_r;
      s10_bpos_r  <= s9_bpos_r;
      s10_fac_r   <= (DW'(s9_p11_r) << 64) + (DW'(s9_p01_r) << 32)
                   + (DW'(s9_p10_r) << 32) + DW'(s9_p00_r);
      s10_bsq_r   <= (DW'(s9_q11_r) << 64) + (DW'(s9_q01_r) << 33) + DW'(s9_q00_r);

      s11_disc_r <= s11_disc_nxt;
      s11_side_r <= s11_side_nxt;
    end
  end

endmodule

### hdl/mpls_sqrt.sv
`timescale 1ns / 1ps
module mpls_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpls_pkg::DISC_W-1:0]   in_disc,
  input  mpls_pkg::side_t               in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpls_pkg::ROOT_W-1:0]   out_root,
  output mpls_pkg::side_t               out_side
);

  localparam int NS = mpls_pkg::SQRT_STAGES;
  localparam int XW = mpls_pkg::DISC_W;
  localparam int RW = mpls_pkg::ROOT_W;
  localparam int EW = mpls_pkg::REM_W;

  logic en;
  logic [NS-1:0] vld_r;

  logic [XW-1:0]   x_r [NS];
  logic [EW-1:0]   rem_r [NS];
  logic [RW-1:0]   root_r [NS];
  mpls_pkg::side_t side_r [NS];

  logic [XW-1:0]   src_x [NS];
  logic [EW-1:0]   src_rem [NS];
  logic [RW-1:0]   src_root [NS];
  mpls_pkg::side_t src_side [NS];

  logic [EW-1:0]   shr [NS];
  logic [EW-1:0]   trial [NS];
  logic [XW-1:0]   x_nxt [NS];
  logic [EW-1:0]   rem_nxt [NS];
  logic [RW-1:0]   root_nxt [NS];

  assign en        = !vld_r[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

  always_comb begin
    src_x[0]    = in_disc;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_side[0] = in_side;
    for (int k = 1; k < NS; k++) begin
      src_x[k]    = x_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      shr[k]   = {src_rem[k][EW-3:0], src_x[k][XW-1:XW-2]};
      trial[k] = {1'b0, src_root[k], 2'b01};
      x_nxt[k] = {src_x[k][XW-3:0], 2'b00};
      if (shr[k] >= trial[k]) begin
        rem_nxt[k]  = shr[k] - trial[k];
        root_nxt[k] = {src_root[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = shr[k];
        root_nxt[k] = {src_root[k][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        x_r[k]    <= x_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> rem_r[NS-1] <= {1'b0, root_r[NS-1], 1'b0})
    else $error("square root remainder exceeds twice the root");

endmodule

### hdl/mpls_div.sv
`timescale 1ns / 1ps
module mpls_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpls_pkg::ROOT_W-1:0]   in_root,
  input  mpls_pkg::side_t               in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpls_pkg::SCALE_W-1:0]  out_scale,
  output logic [31:0]                   out_power,
  output mpls_pkg::tq_t                 out_torque
);

  localparam int NS = mpls_pkg::DIV_STAGES;
  localparam int NW = mpls_pkg::DIVN_W;
  localparam int UW = mpls_pkg::NUM_W;
  localparam int QW = mpls_pkg::QW;
  localparam int SW = mpls_pkg::SCALE_W;

  logic en;

  logic [UW-1:0]   num_nxt;
  logic            neg_nxt;
  logic            pre_vld_r;
  logic [NW-1:0]   pre_n_r;
  logic            pre_neg_r;
  mpls_pkg::side_t pre_side_r;

  logic [NS-1:0]   vld_r;
  logic [NW-1:0]   n_r [NS];
  logic [QW-1:0]   q_r [NS];
  logic            sat_r [NS];
  logic            neg_r [NS];
  mpls_pkg::side_t dside_r [NS];

  logic [NW-1:0]   src_n [NS];
  logic [QW-1:0]   src_q [NS];
  logic            src_sat [NS];
  logic            src_neg [NS];
  mpls_pkg::side_t src_side [NS];
  logic            vld_in [NS];
  logic [NW-1:0]   dsh [NS];
  logic [NW-1:0]   n_nxt [NS];
  logic [QW-1:0]   q_nxt [NS];
  logic            sat_nxt [NS];

  logic [SW-1:0]   mag;
  logic [SW-1:0]   scale_nxt;
  logic            out_vld_r;
  logic [SW-1:0]   scale_r;
  logic [31:0]     power_r;
  mpls_pkg::tq_t   torque_r;

  assign en         = !out_vld_r || out_ready;
  assign in_ready   = en;
  assign out_valid  = out_vld_r;
  assign out_scale  = scale_r;
  assign out_power  = power_r;
  assign out_torque = torque_r;

  always_comb begin
    neg_nxt = 1'b0;
    if (!in_side.b_pos) begin
      num_nxt = UW'(in_root) + UW'(in_side.bm);
    end else if (UW'(in_root) >= UW'(in_side.bm)) begin
      num_nxt = UW'(in_root) - UW'(in_side.bm);
    end else begin
      num_nxt = UW'(in_side.bm) - UW'(in_root);
      neg_nxt = 1'b1;
    end
  end

  always_comb begin
    src_n[0]    = pre_n_r;
    src_q[0]    = '0;
    src_sat[0]  = pre_n_r >= (NW'(pre_side_r.dvs) << QW);
    src_neg[0]  = pre_neg_r;
    src_side[0] = pre_side_r;
    vld_in[0]   = pre_vld_r;
    for (int s = 1; s < NS; s++) begin
      src_n[s]    = n_r[s-1];
      src_q[s]    = q_r[s-1];
      src_sat[s]  = sat_r[s-1];
      src_neg[s]  = neg_r[s-1];
      src_side[s] = dside_r[s-1];
      vld_in[s]   = vld_r[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      dsh[s]     = NW'(src_side[s].dvs) << (NS - 1 - s);
      sat_nxt[s] = src_sat[s];
      if (src_n[s] >= dsh[s]) begin
        n_nxt[s] = src_n[s] - dsh[s];
        q_nxt[s] = src_q[s] | (QW'(1) << (NS - 1 - s));
      end else begin
        n_nxt[s] = src_n[s];
        q_nxt[s] = src_q[s];
      end
    end
  end

  always_comb begin
    mag = sat_r[NS-1] ? mpls_pkg::SCALE_SAT : SW'(q_r[NS-1]);
    unique case (dside_r[NS-1].sel)
      mpls_pkg::SEL_ONE:  scale_nxt = mpls_pkg::SCALE_ONE;
      mpls_pkg::SEL_ROOT: begin
        if (neg_r[NS-1]) begin
          scale_nxt = SW'(-mag);
        end else begin
          scale_nxt = sat_r[NS-1] ? mpls_pkg::SCALE_MAX : mag;
        end
      end
      default:            scale_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= in_valid;
      for (int s = 0; s < NS; s++) begin
        vld_r[s] <= vld_in[s];
      end
      out_vld_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_n_r    <= NW'({num_nxt, 16'h0000});
      pre_neg_r  <= neg_nxt;
      pre_side_r <= in_side;
      for (int s = 0; s < NS; s++) begin
        n_r[s]     <= n_nxt[s];
        q_r[s]     <= q_nxt[s];
        sat_r[s]   <= sat_nxt[s];
        neg_r[s]   <= src_neg[s];
        dside_r[s] <= src_side[s];
      end
      scale_r  <= scale_nxt;
      power_r  <= dside_r[NS-1].power;
      torque_r <= dside_r[NS-1].torque;
    end
  end

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_vld_r)
    else $error("result valid set right after reset");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && !sat_r[NS-1] && (dside_r[NS-1].sel == mpls_pkg::SEL_ROOT)
      |-> n_r[NS-1] < NW'(dside_r[NS-1].dvs))
    else $error("division remainder not below divisor");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(scale_r))
    else $error("scale changed while result stalled");

endmodule

### hdl/motor_power_limit_scale_top.sv
`timescale 1ns / 1ps
// Chassis power limiter. Each transfer on the in_ channel carries four command
// currents and four wheel speeds; the out_ channel returns one result per
// input: the scale to apply to the currents (Q3.16, 65536 = 1.0), the
// modelled total power (Q16.16 watts) and the four motor torques (Q8.24).
// An input transfer passes through the torque, power and discriminant
// arithmetic, a square root that resolves one bit per stage, and the quotient
// and output staging. A new item is taken every cycle while in_tready is high,
// a rate set by the fully pipelined multipliers, root and divider stages.
// Gains and the power limit are to be written by the user on the cfg_ port
// only while the block is idle; the block does not enforce this. Each write
// takes effect at the clock edge where cfg_wen is high. rst_n (synchronous,
// active low) empties the pipeline and loads the default gains and a 60 W
// limit. When out_tready is low the result holds in the output register; the
// front, root and divider sections each stall whole once their last stage is
// full and cannot move on, and in_tready drops while the front one stalls.
module motor_power_limit_scale_top #(
  parameter int MOTOR_COUNT = mpls_pkg::MOTOR_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [mpls_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mpls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // current_cmd_0, current_cmd_1, current_cmd_2, current_cmd_3,
  // speed_0, speed_1, speed_2, speed_3 (16 bits each)
  input  logic [127:0]                       in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // scale_factor (20), estimated_power (32), torque_0..torque_3 (32 each), 4 zero bits
  output logic [183:0]                       out_tdata
);

  mpls_pkg::cfg_t   cfg_r;
  mpls_pkg::fld16_t cur;
  mpls_pkg::fld16_t spd;

  logic                          fr_valid;
  logic                          fr_ready;
  logic [mpls_pkg::DISC_W-1:0]   fr_disc;
  mpls_pkg::side_t               fr_side;
  logic                          sq_valid;
  logic                          sq_ready;
  logic [mpls_pkg::ROOT_W-1:0]   sq_root;
  mpls_pkg::side_t               sq_side;
  logic [mpls_pkg::SCALE_W-1:0]  scale;
  logic [31:0]                   power;
  mpls_pkg::tq_t                 torque;

  always_comb begin
    for (int i = 0; i < mpls_pkg::MOTOR_MAX; i++) begin
      cur[i] = in_tdata[16*i +: 16];
      spd[i] = in_tdata[16*(i + mpls_pkg::MOTOR_MAX) +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k2    <= mpls_pkg::RST_TORQUE_SQ_GAIN;
      cfg_r.k1    <= mpls_pkg::RST_SPEED_SQ_GAIN;
      cfg_r.stat  <= mpls_pkg::RST_STATIC_POWER;
      cfg_r.tgain <= mpls_pkg::RST_TORQUE_GAIN;
      cfg_r.limit <= mpls_pkg::RST_POWER_LIMIT;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        mpls_pkg::REG_TORQUE_SQ_GAIN: cfg_r.k2    <= cfg_wdata;
        mpls_pkg::REG_SPEED_SQ_GAIN:  cfg_r.k1    <= cfg_wdata;
        mpls_pkg::REG_STATIC_POWER:   cfg_r.stat  <= cfg_wdata;
        mpls_pkg::REG_TORQUE_GAIN:    cfg_r.tgain <= cfg_wdata;
        mpls_pkg::REG_POWER_LIMIT:    cfg_r.limit <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  mpls_front #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cur    (cur),
    .in_spd    (spd),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_disc  (fr_disc),
    .out_side  (fr_side)
  );

  mpls_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_disc   (fr_disc),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  mpls_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sq_valid),
    .in_ready   (sq_ready),
    .in_root    (sq_root),
    .in_side    (sq_side),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_scale  (scale),
    .out_power  (power),
    .out_torque (torque)
  );

  assign out_tdata = {4'h0, torque[3], torque[2], torque[1], torque[0], power, scale};

endmodule
